// ===== src/sfm_pkg.sv =====
// Shared types, constants and helper functions for the slip fault monitor.
package sfm_pkg;

   // Field widths
   localparam int RPM_W      = 16;
   localparam int FREQ_W     = 16;
   localparam int MODE_W     = 2;
   localparam int RATIO_W    = 16;
   localparam int POLE_W     = 7;
   localparam int SLIP_W     = 24;
   localparam int DELAY_W    = 16;
   localparam int ERR_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Serial divider geometry: numerator = divisor bits + quotient bits
   localparam int DEN_W  = 18;
   localparam int QUO_W  = SLIP_W;
   localparam int NUM_W  = DEN_W + QUO_W;
   localparam int STEP_W = $clog2(QUO_W);

   typedef logic [NUM_W-1:0]         num_type;
   typedef logic [DEN_W-1:0]         den_type;
   typedef logic [QUO_W-1:0]         quo_type;
   typedef logic [STEP_W-1:0]        step_type;
   typedef logic signed [SLIP_W-1:0] slip_type;

   localparam slip_type SLIP_MAX = {1'b0, {(SLIP_W-1){1'b1}}};
   localparam slip_type SLIP_MIN = {1'b1, {(SLIP_W-1){1'b0}}};

   localparam step_type LAST_STEP = step_type'(QUO_W - 1);

   // Drive modes
   localparam logic [MODE_W-1:0] MODE_RAMP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RUN  = 2'd2;

   // 50 Hz in units of 1/256 Hz
   localparam logic [FREQ_W-1:0] RUN_FREQ = 16'd12800;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_ROTOR = 2'd1;
   localparam logic [ERR_W-1:0] ERR_MOTOR = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_RATIO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLE_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTOR_THR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_THR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_DELAY   = 3'd4;

   // Register reset values
   localparam logic [RATIO_W-1:0] RATIO_RST = 16'd256;
   localparam logic [POLE_W-1:0]  POLE_RST  = 7'd4;
   localparam slip_type           THR_RST   = 24'sd1280;
   localparam logic [DELAY_W-1:0] DELAY_RST = 16'd100;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIFF,
      ST_ABS,
      ST_SCALE,
      ST_LOAD,
      ST_WAIT,
      ST_SAT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic done;
      logic overflow;
   } div_status_type;

   typedef struct packed {
      logic              rotor_fault;
      logic              motor_fault;
      logic [ERR_W-1:0]  error_code;
   } fault_type;

   // Apply sign to a magnitude quotient and clamp to the slip range.
   function automatic slip_type sat_slip(input logic neg, input logic ovf, input quo_type q);
      quo_type  negq;
      slip_type res;
      negq = ~q + 1'b1;
      if (!neg) begin
         res = (ovf || q[QUO_W-1]) ? SLIP_MAX : slip_type'(q);
      end else begin
         res = (ovf || (q[QUO_W-1] && (|q[QUO_W-2:0]))) ? SLIP_MIN : slip_type'(negq);
      end
      return res;
   endfunction

endpackage

// ===== src/sfm_serial_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, overflow flagged at load.
module sfm_serial_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  sfm_pkg::num_type       numer,
   input  sfm_pkg::den_type       denom,
   output sfm_pkg::quo_type       quotient,
   output sfm_pkg::div_status_type status
);

   sfm_pkg::den_type  rem_ff, rem_in;
   sfm_pkg::den_type  den_ff;
   sfm_pkg::quo_type  shift_ff, shift_in;
   sfm_pkg::step_type step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic              ovf_ff;

   logic [sfm_pkg::DEN_W:0] trial;
   logic [sfm_pkg::DEN_W:0] diff;
   logic                    fits;

   // Bring down the next numerator bit and try a subtract
   assign trial = {rem_ff, shift_ff[sfm_pkg::QUO_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      shift_in = shift_ff;
      if (start) begin
         run_in   = 1'b1;
         step_in  = '0;
         rem_in   = numer[sfm_pkg::NUM_W-1 -: sfm_pkg::DEN_W];
         shift_in = numer[sfm_pkg::QUO_W-1:0];
      end else if (run_ff) begin
         rem_in   = fits ? diff[sfm_pkg::DEN_W-1:0] : trial[sfm_pkg::DEN_W-1:0];
         shift_in = {shift_ff[sfm_pkg::QUO_W-2:0], fits};
         step_in  = step_ff + 1'b1;
         if (step_ff == sfm_pkg::LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      if (start) begin
         den_ff <= denom;
         // Quotient needs more than QUO_W bits
         ovf_ff <= numer >= {denom, {sfm_pkg::QUO_W{1'b0}}};
      end
   end

   assign quotient        = shift_ff;
   assign status.done     = done_ff;
   assign status.overflow = ovf_ff;

endmodule

// ===== src/sfm_fault_track.sv =====
// Persistence counters, sticky fault latches and last error code.
module sfm_fault_track (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  logic                          rotor_low,
   input  logic                          motor_low,
   input  logic [sfm_pkg::DELAY_W-1:0]   error_delay,
   output sfm_pkg::fault_type            faults
);

   logic [sfm_pkg::DELAY_W-1:0] rotor_cnt_ff, rotor_cnt_in;
   logic [sfm_pkg::DELAY_W-1:0] motor_cnt_ff, motor_cnt_in;
   logic [sfm_pkg::DELAY_W-1:0] rotor_next, motor_next;
   logic                        rotor_trip, motor_trip;
   sfm_pkg::fault_type          faults_ff, faults_in;

   always_comb begin
      rotor_next = rotor_low ? rotor_cnt_ff + 1'b1 : '0;
      motor_next = motor_low ? motor_cnt_ff + 1'b1 : '0;
      rotor_trip = rotor_next >= error_delay;
      motor_trip = motor_next >= error_delay;

      rotor_cnt_in = rotor_trip ? '0 : rotor_next;
      motor_cnt_in = motor_trip ? '0 : motor_next;

      faults_in = faults_ff;
      if (rotor_trip) begin
         faults_in.rotor_fault = 1'b1;
         if (rotor_low) begin
            faults_in.error_code = sfm_pkg::ERR_ROTOR;
         end
      end
      // Motor handled last: its code wins on the same item
      if (motor_trip) begin
         faults_in.motor_fault = 1'b1;
         if (motor_low) begin
            faults_in.error_code = sfm_pkg::ERR_MOTOR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotor_cnt_ff <= '0;
         motor_cnt_ff <= '0;
         faults_ff    <= '{rotor_fault: 1'b0, motor_fault: 1'b0,
                           error_code: sfm_pkg::ERR_NONE};
      end else if (update) begin
         rotor_cnt_ff <= rotor_cnt_in;
         motor_cnt_ff <= motor_cnt_in;
         faults_ff    <= faults_in;
      end
   end

   assign faults = faults_ff;

endmodule

// ===== src/slip_fault_monitor_unit.sv =====
// Slip fault monitor top level: sequencer, fixed-point datapath and result register.
// Four setup stages, a load state, a wait on the two 24-step serial dividers (run side by
// side), a saturate stage and a hand-over stage; the idle state takes the next item, so a
// new item is accepted only after the last one has been handed over.
// The hand-over stalls while the rsp register holds an item that is not being taken.
// Synchronous active-high reset: config to reset values, control zeroed, no result pending.
module slip_fault_monitor_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Input item channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sfm_pkg::RPM_W-1:0]           req_generator_rpm,
   input  logic [sfm_pkg::RPM_W-1:0]           req_turbine_rpm,
   input  logic [sfm_pkg::MODE_W-1:0]          req_drive_mode,
   input  logic [sfm_pkg::FREQ_W-1:0]          req_ramp_frequency,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [sfm_pkg::SLIP_W-1:0]   rsp_rotor_pct,
   output logic signed [sfm_pkg::SLIP_W-1:0]   rsp_motor_pct,
   output logic                                rsp_slip_ok,
   output logic                                rsp_rotor_fault,
   output logic                                rsp_motor_fault,
   output logic [sfm_pkg::ERR_W-1:0]           rsp_error_code,
   // Configuration writes
   input  logic                                csr_write_en,
   input  logic [sfm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sfm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [sfm_pkg::RATIO_W-1:0] ratio_ff;
   logic [sfm_pkg::POLE_W-1:0]  pole_ff;
   sfm_pkg::slip_type           rotor_thr_ff;
   sfm_pkg::slip_type           motor_thr_ff;
   logic [sfm_pkg::DELAY_W-1:0] delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff     <= sfm_pkg::RATIO_RST;
         pole_ff      <= sfm_pkg::POLE_RST;
         rotor_thr_ff <= sfm_pkg::THR_RST;
         motor_thr_ff <= sfm_pkg::THR_RST;
         delay_ff     <= sfm_pkg::DELAY_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            sfm_pkg::CSR_WHEEL_RATIO: ratio_ff     <= csr_wdata[sfm_pkg::RATIO_W-1:0];
            sfm_pkg::CSR_POLE_COUNT:  pole_ff      <= csr_wdata[sfm_pkg::POLE_W-1:0];
            sfm_pkg::CSR_ROTOR_THR:   rotor_thr_ff <= sfm_pkg::slip_type'(csr_wdata);
            sfm_pkg::CSR_MOTOR_THR:   motor_thr_ff <= sfm_pkg::slip_type'(csr_wdata);
            sfm_pkg::CSR_ERR_DELAY:   delay_ff     <= csr_wdata[sfm_pkg::DELAY_W-1:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   sfm_pkg::state_type      state_ff, state_in;
   sfm_pkg::div_status_type rotor_status, motor_status;
   logic                    div_start;
   logic                    out_load;
   logic                    rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfm_pkg::ST_IDLE:  if (req_valid) state_in = sfm_pkg::ST_MUL;
         sfm_pkg::ST_MUL:   state_in = sfm_pkg::ST_DIFF;
         sfm_pkg::ST_DIFF:  state_in = sfm_pkg::ST_ABS;
         sfm_pkg::ST_ABS:   state_in = sfm_pkg::ST_SCALE;
         sfm_pkg::ST_SCALE: state_in = sfm_pkg::ST_LOAD;
         sfm_pkg::ST_LOAD:  state_in = sfm_pkg::ST_WAIT;
         sfm_pkg::ST_WAIT: begin
            if (rotor_status.done && motor_status.done) state_in = sfm_pkg::ST_SAT;
         end
         sfm_pkg::ST_SAT:   state_in = sfm_pkg::ST_DONE;
         sfm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = sfm_pkg::ST_IDLE;
         end
         default:           state_in = sfm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         sfm_pkg::ST_IDLE: req_ready = 1'b1;
         sfm_pkg::ST_LOAD: div_start = 1'b1;
         // Hand the result over once the rsp slot is free or being emptied
         sfm_pkg::ST_DONE: out_load  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------
   // Item capture and frequency selection
   // ---------------------------------------------------------------
   logic [sfm_pkg::RPM_W-1:0]  gen_ff;
   logic [sfm_pkg::RPM_W-1:0]  tur_ff;
   logic [sfm_pkg::FREQ_W-1:0] held_ff, held_in;
   logic                       req_take;

   assign req_take = req_valid && req_ready;

   always_comb begin
      held_in = held_ff;
      case (req_drive_mode)
         sfm_pkg::MODE_RAMP: held_in = req_ramp_frequency;
         sfm_pkg::MODE_RUN:  held_in = sfm_pkg::RUN_FREQ;
         default:            held_in = held_ff;  // other modes hold
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (req_take) begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         gen_ff <= req_generator_rpm;
         tur_ff <= req_turbine_rpm;
      end
   end

   // ---------------------------------------------------------------
   // Datapath: products, differences, magnitudes, scaled numerators
   // rotor: (tur*ratio - 256*gen)*100 / gen
   // motor: (256*gen*poles - 120*h)*640 / (3*h)
   // ---------------------------------------------------------------
   localparam int PROD_R_W = 2 * sfm_pkg::RPM_W;
   localparam int PROD_M_W = sfm_pkg::RPM_W + sfm_pkg::POLE_W;
   localparam int DIFF_R_W = PROD_R_W + 1;
   localparam int DIFF_M_W = PROD_M_W + 9;
   localparam int MAG_R_W  = DIFF_R_W - 1;
   localparam int MAG_M_W  = DIFF_M_W - 1;

   logic [PROD_R_W-1:0]       prod_r_ff;
   logic [PROD_M_W-1:0]       prod_m_ff;
   logic [PROD_M_W-1:0]       h120;
   logic signed [DIFF_R_W-1:0] diff_r_ff;
   logic signed [DIFF_M_W-1:0] diff_m_ff;
   logic [DIFF_R_W-1:0]       neg_diff_r;
   logic [DIFF_M_W-1:0]       neg_diff_m;
   logic [MAG_R_W-1:0]        mag_r_ff;
   logic [MAG_M_W-1:0]        mag_m_ff;
   logic                      neg_r_ff, neg_m_ff;
   sfm_pkg::num_type          num_r_ff, num_m_ff;
   sfm_pkg::den_type          den_r_ff, den_m_ff;

   // 120*h as 128*h - 8*h
   assign h120 = {held_ff, 7'b0} - {4'b0, held_ff, 3'b0};

   assign neg_diff_r = '0 - diff_r_ff;
   assign neg_diff_m = '0 - diff_m_ff;

   always_ff @(posedge clock) begin
      case (state_ff)
         sfm_pkg::ST_MUL: begin
            prod_r_ff <= {{sfm_pkg::RPM_W{1'b0}}, tur_ff} * PROD_R_W'(ratio_ff);
            prod_m_ff <= PROD_M_W'(gen_ff) * PROD_M_W'(pole_ff);
         end
         sfm_pkg::ST_DIFF: begin
            diff_r_ff <= $signed({1'b0, prod_r_ff}) - $signed({9'b0, gen_ff, 8'b0});
            diff_m_ff <= $signed({1'b0, prod_m_ff, 8'b0}) - $signed({9'b0, h120});
         end
         sfm_pkg::ST_ABS: begin
            neg_r_ff <= diff_r_ff[DIFF_R_W-1];
            neg_m_ff <= diff_m_ff[DIFF_M_W-1];
            mag_r_ff <= diff_r_ff[DIFF_R_W-1] ? neg_diff_r[MAG_R_W-1:0]
                                              : diff_r_ff[MAG_R_W-1:0];
            mag_m_ff <= diff_m_ff[DIFF_M_W-1] ? neg_diff_m[MAG_M_W-1:0]
                                              : diff_m_ff[MAG_M_W-1:0];
         end
         sfm_pkg::ST_SCALE: begin
            // x100 = 64x + 32x + 4x, x640 = 512x + 128x
            num_r_ff <= sfm_pkg::num_type'({mag_r_ff, 6'b0})
                      + sfm_pkg::num_type'({mag_r_ff, 5'b0})
                      + sfm_pkg::num_type'({mag_r_ff, 2'b0});
            num_m_ff <= sfm_pkg::num_type'({mag_m_ff, 9'b0})
                      + sfm_pkg::num_type'({mag_m_ff, 7'b0});
            den_r_ff <= sfm_pkg::den_type'(gen_ff);
            den_m_ff <= sfm_pkg::den_type'(held_ff) + sfm_pkg::den_type'({held_ff, 1'b0});
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------
   // Serial dividers, one per slip
   // ---------------------------------------------------------------
   sfm_pkg::quo_type rotor_quo, motor_quo;

   sfm_serial_div u_rotor_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (num_r_ff),
      .denom    (den_r_ff),
      .quotient (rotor_quo),
      .status   (rotor_status)
   );

   sfm_serial_div u_motor_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (num_m_ff),
      .denom    (den_m_ff),
      .quotient (motor_quo),
      .status   (motor_status)
   );

   // ---------------------------------------------------------------
   // Sign, saturation and zero-divisor handling
   // ---------------------------------------------------------------
   sfm_pkg::slip_type rslip_ff, mslip_ff;

   always_ff @(posedge clock) begin
      if (state_ff == sfm_pkg::ST_SAT) begin
         // Zero speed or zero frequency reads as full positive slip
         rslip_ff <= (gen_ff == '0) ? sfm_pkg::SLIP_MAX
                   : sfm_pkg::sat_slip(neg_r_ff, rotor_status.overflow, rotor_quo);
         mslip_ff <= (held_ff == '0) ? sfm_pkg::SLIP_MAX
                   : sfm_pkg::sat_slip(neg_m_ff, motor_status.overflow, motor_quo);
      end
   end

   // ---------------------------------------------------------------
   // Threshold checks, persistence tracking and result register
   // ---------------------------------------------------------------
   logic               rotor_low, motor_low;
   logic               slip_ok_ff;
   sfm_pkg::fault_type faults;

   assign rotor_low = rslip_ff < rotor_thr_ff;
   assign motor_low = mslip_ff < motor_thr_ff;

   sfm_fault_track u_fault_track (
      .clock       (clock),
      .reset       (reset),
      .update      (out_load),
      .rotor_low   (rotor_low),
      .motor_low   (motor_low),
      .error_delay (delay_ff),
      .faults      (faults)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   logic signed [sfm_pkg::SLIP_W-1:0] rsp_rslip_ff, rsp_mslip_ff;

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_rslip_ff <= rslip_ff;
         rsp_mslip_ff <= mslip_ff;
         slip_ok_ff   <= (rslip_ff > rotor_thr_ff) && (mslip_ff > motor_thr_ff);
      end
   end

   // Fault fields come straight from the tracker; it only advances on out_load
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rotor_pct   = rsp_rslip_ff;
   assign rsp_motor_pct   = rsp_mslip_ff;
   assign rsp_slip_ok     = slip_ok_ff;
   assign rsp_rotor_fault = faults.rotor_fault;
   assign rsp_motor_fault = faults.motor_fault;
   assign rsp_error_code  = faults.error_code;

endmodule

// ===== src/sfm_port_checker.sv =====
// Port-level checks for the slip fault monitor, bound to the top level.
module sfm_port_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [sfm_pkg::SLIP_W-1:0]   rsp_rotor_pct,
   input logic signed [sfm_pkg::SLIP_W-1:0]   rsp_motor_pct,
   input logic                                rsp_slip_ok,
   input logic                                rsp_rotor_fault,
   input logic                                rsp_motor_fault,
   input logic [sfm_pkg::ERR_W-1:0]           rsp_error_code
);

   logic seen_rotor_ff;
   logic seen_motor_ff;

   // Remember faults already delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_rotor_ff <= 1'b0;
         seen_motor_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         if (rsp_rotor_fault) seen_rotor_ff <= 1'b1;
         if (rsp_motor_fault) seen_motor_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rotor_pct)
         && $stable(rsp_motor_pct) && $stable(rsp_slip_ok) && $stable(rsp_error_code))
      else $error("rsp item changed while stalled");

   a_rotor_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_rotor_ff |-> rsp_rotor_fault)
      else $error("rotor fault flag cleared after being reported");

   a_motor_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_motor_ff |-> rsp_motor_fault)
      else $error("motor fault flag cleared after being reported");

   a_code_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code == sfm_pkg::ERR_NONE)
         || (rsp_error_code == sfm_pkg::ERR_ROTOR && rsp_rotor_fault)
         || (rsp_error_code == sfm_pkg::ERR_MOTOR && rsp_motor_fault))
      else $error("error code without matching fault flag");

endmodule

bind slip_fault_monitor_unit sfm_port_checker u_port_checker (.*);

// ===== dv/slip_fault_monitor_checker.sv =====
// Result checker for the slip fault monitor: tracks config, forecasts each tick, compares results.
`timescale 1ns / 1ps
module slip_fault_monitor_checker
   import sfm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [RPM_W-1:0]        req_generator_rpm,
   input  logic [RPM_W-1:0]        req_turbine_rpm,
   input  logic [MODE_W-1:0]       req_drive_mode,
   input  logic [FREQ_W-1:0]       req_ramp_frequency,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [SLIP_W-1:0] rsp_rotor_pct,
   input  logic signed [SLIP_W-1:0] rsp_motor_pct,
   input  logic                    rsp_slip_ok,
   input  logic                    rsp_rotor_fault,
   input  logic                    rsp_motor_fault,
   input  logic [ERR_W-1:0]        rsp_error_code,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      pending_results,
   output int                      mismatch_count
);

   typedef struct packed {
      slip_type         rotor_pct;
      slip_type         motor_pct;
      logic             slip_ok;
      logic             rotor_fault;
      logic             motor_fault;
      logic [ERR_W-1:0] error_code;
   } tick_result_type;

   // Shadow registers and monitor state
   logic [RATIO_W-1:0] ratio_q;
   logic [POLE_W-1:0]  poles_q;
   slip_type           rotor_limit;
   slip_type           motor_limit;
   logic [DELAY_W-1:0] delay_q;
   logic [FREQ_W-1:0]  drive_freq;
   logic [DELAY_W-1:0] rotor_low_count;
   logic [DELAY_W-1:0] motor_low_count;
   logic               rotor_latch;
   logic               motor_latch;
   logic [ERR_W-1:0]   last_code;

   tick_result_type slip_forecast[$];

   function automatic slip_type clamp_slip(input longint v);
      if (v > longint'(SLIP_MAX))
         return SLIP_MAX;
      if (v < longint'(SLIP_MIN))
         return SLIP_MIN;
      return slip_type'(v);
   endfunction

   // Advance the monitor state by one tick and return the result it reports.
   function automatic tick_result_type forecast_tick(input logic [RPM_W-1:0] gen,
         input logic [RPM_W-1:0] tur, input logic [MODE_W-1:0] mode,
         input logic [FREQ_W-1:0] ramp);
      tick_result_type r;
      longint g;
      longint h;
      longint diff;
      g = longint'(gen);
      if (g == 0) begin
         r.rotor_pct = SLIP_MAX;
      end else begin
         diff = longint'(tur) * longint'(ratio_q) - 256 * g;
         r.rotor_pct = clamp_slip(diff * 100 / g);
      end

      if (mode == MODE_RAMP) begin
         drive_freq = ramp;
      end else if (mode == MODE_RUN) begin
         drive_freq = RUN_FREQ;
      end
      h = longint'(drive_freq);
      if (h == 0) begin
         r.motor_pct = SLIP_MAX;
      end else begin
         diff = 256 * g * longint'(poles_q) - 120 * h;
         r.motor_pct = clamp_slip(diff * 640 / (3 * h));
      end

      r.slip_ok = (r.rotor_pct > rotor_limit) && (r.motor_pct > motor_limit);

      // Rotor first, so a motor trip on the same tick owns the code
      if (r.rotor_pct < rotor_limit)
         rotor_low_count = rotor_low_count + 1'b1;
      else
         rotor_low_count = '0;
      if (rotor_low_count >= delay_q) begin
         rotor_low_count = '0;
         rotor_latch = 1'b1;
         if (r.rotor_pct < rotor_limit)
            last_code = ERR_ROTOR;
      end

      if (r.motor_pct < motor_limit)
         motor_low_count = motor_low_count + 1'b1;
      else
         motor_low_count = '0;
      if (motor_low_count >= delay_q) begin
         motor_low_count = '0;
         motor_latch = 1'b1;
         if (r.motor_pct < motor_limit)
            last_code = ERR_MOTOR;
      end

      r.rotor_fault = rotor_latch;
      r.motor_fault = motor_latch;
      r.error_code  = last_code;
      return r;
   endfunction

   task automatic compare_field(input string field, input longint want, input longint got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      tick_result_type want;
      if (reset) begin
         ratio_q         = RATIO_RST;
         poles_q         = POLE_RST;
         rotor_limit     = THR_RST;
         motor_limit     = THR_RST;
         delay_q         = DELAY_RST;
         drive_freq      = '0;
         rotor_low_count = '0;
         motor_low_count = '0;
         rotor_latch     = 1'b0;
         motor_latch     = 1'b0;
         last_code       = ERR_NONE;
         slip_forecast.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_WHEEL_RATIO: ratio_q = csr_wdata[RATIO_W-1:0];
               CSR_POLE_COUNT:  poles_q = csr_wdata[POLE_W-1:0];
               CSR_ROTOR_THR:   rotor_limit = slip_type'(csr_wdata);
               CSR_MOTOR_THR:   motor_limit = slip_type'(csr_wdata);
               CSR_ERR_DELAY:   delay_q = csr_wdata[DELAY_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            slip_forecast.push_back(forecast_tick(req_generator_rpm, req_turbine_rpm,
                                                  req_drive_mode, req_ramp_frequency));
         if (rsp_valid && rsp_ready) begin
            if (slip_forecast.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with nothing outstanding: rotor %0d motor %0d",
                           $realtime, rsp_rotor_pct, rsp_motor_pct);
            end else begin
               want = slip_forecast.pop_front();
               compare_field("rotor_pct", longint'(want.rotor_pct), longint'(rsp_rotor_pct));
               compare_field("motor_pct", longint'(want.motor_pct), longint'(rsp_motor_pct));
               compare_field("slip_ok", longint'(want.slip_ok), longint'(rsp_slip_ok));
               compare_field("rotor_fault", longint'(want.rotor_fault),
                             longint'(rsp_rotor_fault));
               compare_field("motor_fault", longint'(want.motor_fault),
                             longint'(rsp_motor_fault));
               compare_field("error_code", longint'(want.error_code),
                             longint'(rsp_error_code));
            end
         end
      end
      pending_results <= slip_forecast.size();
   end

endmodule

// ===== dv/slip_fault_monitor_unit_test.sv =====
// Testbench top for the slip fault monitor: clock, reset, stimulus phases and the verdict.
`timescale 1ns / 1ps
module slip_fault_monitor_unit_test;
   import sfm_pkg::*;

   // Drive modes the package leaves unnamed
   localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   // First register index that decodes to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = CSR_ERR_DELAY + 1'b1;

   localparam int PHASE_COUNT = 8;
   localparam int PHASE_TICKS = 125;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY_FOURTH, STALL_LONG} stall_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [RPM_W-1:0]         req_generator_rpm = '0;
   logic [RPM_W-1:0]         req_turbine_rpm = '0;
   logic [MODE_W-1:0]        req_drive_mode = '0;
   logic [FREQ_W-1:0]        req_ramp_frequency = '0;

   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [SLIP_W-1:0] rsp_rotor_pct;
   logic signed [SLIP_W-1:0] rsp_motor_pct;
   logic                     rsp_slip_ok;
   logic                     rsp_rotor_fault;
   logic                     rsp_motor_fault;
   logic [ERR_W-1:0]         rsp_error_code;

   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   int pending_results;
   int mismatch_count;

   // Stimulus-side copy of the settings, used only to aim slips near their limits
   logic [RATIO_W-1:0] cfg_ratio = RATIO_RST;
   logic [POLE_W-1:0]  cfg_poles = POLE_RST;

   stall_style_type stall_style = STALL_NONE;
   int stall_cycle = 0;
   int stall_run = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   slip_fault_monitor_unit uut (.*);

   slip_fault_monitor_checker slip_checker (.*);

   // Back-pressure: pick a new stall style whenever the style counter wraps. The long style
   // holds ready low until its countdown runs out; the none style gives clean stretches.
   always @(negedge clock) begin
      if (stall_cycle == 0)
         stall_style = stall_style_type'($urandom_range(0, 3));
      stall_cycle = (stall_cycle + 1) % 64;
      case (stall_style)
         STALL_NONE:         rsp_ready <= 1'b1;
         STALL_COIN:         rsp_ready <= ($urandom_range(0, 1) == 1);
         STALL_EVERY_FOURTH: rsp_ready <= (stall_cycle % 4 == 0);
         default: begin
            if (stall_run == 0)
               stall_run = $urandom_range(1, 40);
            stall_run = stall_run - 1;
            rsp_ready <= (stall_run == 0);
         end
      endcase
   end

   function automatic logic [15:0] fit16(input longint v);
      if (v < 0)
         return 16'd0;
      if (v > 65535)
         return 16'hFFFF;
      return v[15:0];
   endfunction

   // Write one register for a single cycle; junk above the field width when asked.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value,
                            input int width, input bit junk_upper);
      logic [CSR_DATA_W-1:0] data;
      data = value;
      if (junk_upper && width < CSR_DATA_W)
         data = (CSR_DATA_W'($urandom) << width) | value;
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = data;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Present one item and hold it until the block takes it. Valid stays high
   // afterwards so that back-to-back items need no bubble.
   task automatic send_tick(input logic [RPM_W-1:0] gen, input logic [RPM_W-1:0] tur,
                            input logic [MODE_W-1:0] mode, input logic [FREQ_W-1:0] ramp);
      @(negedge clock);
      req_valid          = 1'b1;
      req_generator_rpm  = gen;
      req_turbine_rpm    = tur;
      req_drive_mode     = mode;
      req_ramp_frequency = ramp;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // Mostly plausible drive ticks with both slips aimed within about 20 percent,
   // so the limits and persistence counters get exercised; the rest is raw noise.
   task automatic send_random_tick();
      logic [RPM_W-1:0]  gen;
      logic [RPM_W-1:0]  tur;
      logic [MODE_W-1:0] mode;
      logic [FREQ_W-1:0] ramp;
      int pick;
      int rotor_aim;
      int motor_aim;
      longint g;
      longint p;
      gen  = RPM_W'($urandom);
      tur  = RPM_W'($urandom);
      mode = MODE_W'($urandom);
      ramp = FREQ_W'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         rotor_aim = $urandom_range(0, 40);
         rotor_aim = rotor_aim - 20;
         motor_aim = $urandom_range(0, 40);
         motor_aim = motor_aim - 20;
         p = longint'(cfg_poles);
         g = longint'($urandom_range(1, 12000));
         mode = (pick < 3) ? MODE_RAMP : ((pick < 6) ? MODE_RUN : MODE_IDLE);
         if (mode == MODE_RUN && p != 0)
            g = 6000 * (100 + motor_aim) / (p * 100);
         if (mode == MODE_RAMP && p != 0)
            ramp = fit16(256 * g * p * 100 / (120 * (100 + motor_aim)));
         gen = fit16(g);
         if (cfg_ratio != 0)
            tur = fit16(256 * g * (100 + rotor_aim) / (100 * longint'(cfg_ratio)));
      end
      send_tick(gen, tur, mode, ramp);
   endtask

   // Stop offering items and hold off until every outstanding result is back.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results != 0)
         @(negedge clock);
   endtask

   // Load the settings of one phase; phase 0 runs on the reset values.
   task automatic load_phase(input int phase);
      logic [RATIO_W-1:0] ratio;
      logic [POLE_W-1:0]  poles;
      slip_type           rotor_thr;
      slip_type           motor_thr;
      logic [DELAY_W-1:0] delay;
      bit                 junk;
      junk = 1'b0;
      case (phase)
         1: begin
            // widest ratio, 64 poles, thresholds at opposite extremes, instant trips
            ratio = 16'hFFFF; poles = 7'd64; rotor_thr = SLIP_MIN; motor_thr = SLIP_MAX;
            delay = 16'd0;
         end
         2: begin
            ratio = 16'd1; poles = 7'd2; rotor_thr = SLIP_MAX; motor_thr = SLIP_MIN;
            delay = 16'hFFFF;
         end
         3: begin
            // zero pole count pins motor slip at -100 percent
            ratio = RATIO_RST; poles = 7'd0; rotor_thr = '0; motor_thr = '0; delay = 16'd1;
         end
         4: begin
            ratio = 16'd0; poles = 7'h7F; rotor_thr = -24'sd1280; motor_thr = 24'sd2560;
            delay = 16'd3;
         end
         default: begin
            ratio     = RATIO_W'($urandom_range(128, 512));
            poles     = POLE_W'($urandom_range(2, 64));
            rotor_thr = slip_type'($urandom_range(0, 6000)) - 24'sd3000;
            motor_thr = slip_type'($urandom_range(0, 6000)) - 24'sd3000;
            delay     = DELAY_W'($urandom_range(0, 10));
            junk      = 1'b1;
         end
      endcase
      write_reg(CSR_WHEEL_RATIO, CSR_DATA_W'(ratio), RATIO_W, junk);
      write_reg(CSR_POLE_COUNT, CSR_DATA_W'(poles), POLE_W, junk);
      write_reg(CSR_ROTOR_THR, rotor_thr, SLIP_W, junk);
      write_reg(CSR_MOTOR_THR, motor_thr, SLIP_W, junk);
      write_reg(CSR_ERR_DELAY, CSR_DATA_W'(delay), DELAY_W, junk);
      // Poke the undecoded indexes once; they must leave the settings alone
      if (phase == 5) begin
         for (int idx = CSR_SPARE_FIRST; idx < (1 << CSR_IDX_W); idx++)
            write_reg(CSR_IDX_W'(idx), CSR_DATA_W'($urandom), CSR_DATA_W, 1'b0);
      end
      cfg_ratio = ratio;
      cfg_poles = poles;
   endtask

   // Fixed ticks on reset settings: field extremes, every drive mode and the
   // corner cases (zero speed, zero held frequency, saturation, exact limits).
   task automatic send_directed_ticks();
      send_tick(16'd0, 16'd0, MODE_IDLE, 16'd0);             // nothing held yet, zero speed
      send_tick(16'hFFFF, 16'hFFFF, MODE_SPARE, 16'hFFFF);   // unused mode keeps zero
      send_tick(16'd1, 16'hFFFF, MODE_RAMP, 16'hFFFF);       // rotor slip saturates high
      send_tick(16'hFFFF, 16'd0, MODE_RAMP, 16'd1);          // motor slip saturates high
      send_tick(16'd1, 16'd0, MODE_RAMP, 16'hFFFF);          // both near -100 percent
      send_tick(16'd1575, 16'd1600, MODE_RUN, 16'd0);        // motor slip on its limit
      send_tick(16'd100, 16'd105, MODE_IDLE, 16'h1234);      // rotor slip on its limit
      send_tick(16'd1500, 16'd1500, MODE_RUN, 16'hFFFF);     // synchronous, zero slips
      send_tick(16'd1600, 16'd1700, MODE_RUN, 16'd0);        // both above limits
      send_tick(16'hAAAA, 16'h5555, MODE_RAMP, 16'h5555);
      send_tick(16'h5555, 16'hAAAA, MODE_RUN, 16'hAAAA);
      send_tick(16'd1500, 16'd1500, MODE_SPARE, 16'd0);      // holds 50 Hz
      send_tick(16'd800, 16'd820, MODE_RAMP, 16'd0);         // ramp back to zero frequency
      send_tick(16'd1, 16'd1, MODE_IDLE, 16'hFFFF);
   endtask

   initial begin
      #1_500_000;
      $display("slip_fault_monitor_unit regression: fail");
      $finish;
   end

   initial begin
      int ticks_left;
      int burst;
      int gap;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // Settings only change with the block idle
         drain_results();
         if (phase == 0)
            send_directed_ticks();
         else
            load_phase(phase);

         ticks_left = PHASE_TICKS;
         while (ticks_left > 0) begin
            burst = $urandom_range(1, 20);
            for (int n = 0; n < burst && ticks_left > 0; n++) begin
               send_random_tick();
               ticks_left--;
            end
            // Idle gaps of random length land on every stage of the block's work
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap != 0) begin
               @(negedge clock);
               req_valid = 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
      end

      drain_results();
      repeat (40) @(negedge clock);
      if (mismatch_count == 0)
         $display("slip_fault_monitor_unit regression: pass");
      else
         $display("slip_fault_monitor_unit regression: fail");
      $finish;
   end

endmodule
